// ===== sv/cubic_bezier_tessellator_macros.svh =====
// ---------------------------------------------------------------------------
// cubic bezier tessellator assertion macros
// shared concurrent assertion wrappers, clocked on clock, quiet in reset
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_TESSELLATOR_MACROS_SVH
`define CUBIC_BEZIER_TESSELLATOR_MACROS_SVH

// property checked at every rising edge outside reset, fixed message
`define CBT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cbt assertion failed");

// same with a caller supplied message string
`define CBT_ASSERT_MSG(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`endif

// ===== sv/cbt_pkg.sv =====
// ---------------------------------------------------------------------------
// cbt_pkg
// shared widths, register indexes, controller states and command/status types
// ---------------------------------------------------------------------------
package cbt_pkg;

   localparam int COORD_W   = 24;
   localparam int T_W       = 17;
   localparam int T_FRAC    = 16;
   localparam int COUNT_W   = 6;
   localparam int INDEX_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [T_W-1:0]     T_STEP_RESET        = 17'd3277;
   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET  = 6'd21;
   localparam logic [INDEX_W-1:0] RESTART_INDEX_RESET = 32'hFFFF_FFFF;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_T_STEP        = 2'd0,
      CSR_SAMPLE_COUNT  = 2'd1,
      CSR_RESTART_INDEX = 2'd2
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LVL1  = 6'b000010,
      ST_LVL2  = 6'b000100,
      ST_LVL3  = 6'b001000,
      ST_POINT = 6'b010000,
      ST_MARK  = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic lvl1;
      logic lvl2;
      logic lvl3;
      logic emit_point;
      logic emit_marker;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic last_sample;
      logic no_samples;
   } sts_type;

endpackage

// ===== sv/cbt_datapath.sv =====
// ---------------------------------------------------------------------------
// cbt_datapath
// control point store, shared de casteljau lerp lanes, t stepping, vertex
// counter and the result output register
// ---------------------------------------------------------------------------
module cbt_datapath
   import cbt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  coord_type           cp_in [4][3],
   input  logic [T_W-1:0]      t_step,
   input  logic [COUNT_W-1:0]  sample_count,
   input  logic [INDEX_W-1:0]  restart_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output coord_type           rsp_point_x,
   output coord_type           rsp_point_y,
   output coord_type           rsp_point_z,
   output logic [T_W-1:0]      rsp_param_t,
   output logic [INDEX_W-1:0]  rsp_element_index,
   output logic                rsp_is_restart,
   output logic                rsp_last
);

   localparam int PROD_W = COORD_W + T_W + 2;
   localparam int QUO_W  = PROD_W - T_FRAC;
   localparam logic [T_W:0] T_ONE = (T_W+1)'(1) << T_FRAC;

   // a + floor((b - a) * t / 2^16), result between a and b while t is at most 1.0
   function automatic coord_type lerp(input coord_type a, input coord_type b,
                                      input logic [T_W-1:0] t);
      logic signed [COORD_W:0]  diff;
      logic signed [PROD_W-1:0] prod;
      logic signed [QUO_W-1:0]  sum;
      diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
      prod = diff * $signed({1'b0, t});
      sum  = prod[PROD_W-1:T_FRAC] + {{(QUO_W-COORD_W){a[COORD_W-1]}}, a};
      return sum[COORD_W-1:0];
   endfunction

   coord_type              cp_ff   [4][3];
   coord_type              lvl_ff  [3][3];
   coord_type              lane_out[3][3];
   logic [T_W-1:0]         t_ff, t_in;
   logic [T_W:0]           t_sum;
   logic [COUNT_W-1:0]     k_ff;
   logic [INDEX_W-1:0]     vertex_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   coord_type              pt_x_ff, pt_y_ff, pt_z_ff;
   logic [T_W-1:0]         param_t_ff;
   logic [INDEX_W-1:0]     elem_ff;
   logic                   restart_ff, last_ff;

   // lane j interpolates neighbors j and j+1; level 1 reads the control points
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int j = 0; j < 2; j++) begin
            lane_out[c][j] = cmd.lvl1 ? lerp(cp_ff[j][c], cp_ff[j+1][c], t_ff)
                                      : lerp(lvl_ff[c][j], lvl_ff[c][j+1], t_ff);
         end
         lane_out[c][2] = lerp(cp_ff[2][c], cp_ff[3][c], t_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cp_ff <= cp_in;
      end
      if (cmd.lvl1) begin
         lvl_ff <= lane_out;
      end else if (cmd.lvl2 || cmd.lvl3) begin
         for (int c = 0; c < 3; c++) begin
            lvl_ff[c][0] <= lane_out[c][0];
            lvl_ff[c][1] <= lane_out[c][1];
         end
      end
   end

   // saturating t accumulator
   always_comb begin
      t_sum = {1'b0, t_ff} + {1'b0, t_step};
      t_in  = (t_sum > T_ONE) ? T_ONE[T_W-1:0] : t_sum[T_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff      <= '0;
         k_ff      <= '0;
         vertex_ff <= '0;
      end else if (cmd.load) begin
         t_ff <= '0;
         k_ff <= '0;
      end else if (cmd.emit_point) begin
         t_ff      <= t_in;
         k_ff      <= k_ff + COUNT_W'(1);
         vertex_ff <= vertex_ff + INDEX_W'(1);
      end
   end

   // output register
   always_comb begin
      if (cmd.emit_point || cmd.emit_marker) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_point) begin
         pt_x_ff    <= lvl_ff[0][0];
         pt_y_ff    <= lvl_ff[1][0];
         pt_z_ff    <= lvl_ff[2][0];
         param_t_ff <= t_ff;
         elem_ff    <= vertex_ff;
         restart_ff <= 1'b0;
         last_ff    <= 1'b0;
      end else if (cmd.emit_marker) begin
         pt_x_ff    <= '0;
         pt_y_ff    <= '0;
         pt_z_ff    <= '0;
         param_t_ff <= '0;
         elem_ff    <= restart_index;
         restart_ff <= 1'b1;
         last_ff    <= 1'b1;
      end
   end

   assign sts.slot_free   = ~rsp_valid_ff | ~rsp_stall;
   assign sts.last_sample = ({1'b0, k_ff} + (COUNT_W+1)'(1)) == {1'b0, sample_count};
   assign sts.no_samples  = (sample_count == '0);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_x       = pt_x_ff;
   assign rsp_point_y       = pt_y_ff;
   assign rsp_point_z       = pt_z_ff;
   assign rsp_param_t       = param_t_ff;
   assign rsp_element_index = elem_ff;
   assign rsp_is_restart    = restart_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== sv/cbt_ctrl.sv =====
// ---------------------------------------------------------------------------
// cbt_ctrl
// sequencer: accepts a curve, steps the three lerp levels per sample, loads
// each point and then the restart marker into the output register
// ---------------------------------------------------------------------------
`include "cubic_bezier_tessellator_macros.svh"

module cbt_ctrl
   import cbt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.no_samples ? ST_MARK : ST_LVL1;
            end
         end
         ST_LVL1: begin
            cmd.lvl1 = 1'b1;
            state_in = ST_LVL2;
         end
         ST_LVL2: begin
            cmd.lvl2 = 1'b1;
            state_in = ST_LVL3;
         end
         ST_LVL3: begin
            cmd.lvl3 = 1'b1;
            state_in = ST_POINT;
         end
         ST_POINT: begin
            if (sts.slot_free) begin
               cmd.emit_point = 1'b1;
               state_in = sts.last_sample ? ST_MARK : ST_LVL1;
            end
         end
         ST_MARK: begin
            if (sts.slot_free) begin
               cmd.emit_marker = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   `CBT_ASSERT(a_accept_starts_run,
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_LVL1 || state_ff == ST_MARK))
   `CBT_ASSERT_MSG(a_emit_into_free_slot,
      (cmd.emit_point || cmd.emit_marker) |-> sts.slot_free,
      "result loaded while output register still held")
   `CBT_ASSERT_MSG(a_marker_ends_run,
      cmd.emit_marker |=> (state_ff == ST_IDLE),
      "run did not end after restart marker")

endmodule

// ===== sv/cubic_bezier_tessellator.sv =====
// ---------------------------------------------------------------------------
// cubic_bezier_tessellator
// cubic bezier tessellation by de casteljau evaluation with restart markers
// ---------------------------------------------------------------------------
// Each accepted curve produces sample_count points at t = min(k*t_step, 1.0)
// followed by one restart marker carrying restart_index. Each point passes
// three interpolation levels through one shared bank of nine multiply-add
// lanes (three per axis), then the load into the output register. The next
// curve is taken while the marker still waits in the output register. Write
// configuration only while no curve is in flight.
module cubic_bezier_tessellator
   import cbt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  coord_type             req_p0_x,
   input  coord_type             req_p0_y,
   input  coord_type             req_p0_z,
   input  coord_type             req_p1_x,
   input  coord_type             req_p1_y,
   input  coord_type             req_p1_z,
   input  coord_type             req_p2_x,
   input  coord_type             req_p2_y,
   input  coord_type             req_p2_z,
   input  coord_type             req_p3_x,
   input  coord_type             req_p3_y,
   input  coord_type             req_p3_z,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output coord_type             rsp_point_x,
   output coord_type             rsp_point_y,
   output coord_type             rsp_point_z,
   output logic [T_W-1:0]        rsp_param_t,
   output logic [INDEX_W-1:0]    rsp_element_index,
   output logic                  rsp_is_restart,
   output logic                  rsp_last
);

   logic [T_W-1:0]      t_step_ff;
   logic [COUNT_W-1:0]  sample_count_ff;
   logic [INDEX_W-1:0]  restart_index_ff;
   coord_type           cp      [4][3];
   cmd_type             cmd;
   sts_type             sts;

   // configuration registers, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         t_step_ff        <= T_STEP_RESET;
         sample_count_ff  <= SAMPLE_COUNT_RESET;
         restart_index_ff <= RESTART_INDEX_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_T_STEP:        t_step_ff        <= csr_wdata[T_W-1:0];
            CSR_SAMPLE_COUNT:  sample_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_RESTART_INDEX: restart_index_ff <= csr_wdata[INDEX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cp[0][0] = req_p0_x;
   assign cp[0][1] = req_p0_y;
   assign cp[0][2] = req_p0_z;
   assign cp[1][0] = req_p1_x;
   assign cp[1][1] = req_p1_y;
   assign cp[1][2] = req_p1_z;
   assign cp[2][0] = req_p2_x;
   assign cp[2][1] = req_p2_y;
   assign cp[2][2] = req_p2_z;
   assign cp[3][0] = req_p3_x;
   assign cp[3][1] = req_p3_y;
   assign cp[3][2] = req_p3_z;

   cbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .cp_in             (cp),
      .t_step            (t_step_ff),
      .sample_count      (sample_count_ff),
      .restart_index     (restart_index_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_point_z       (rsp_point_z),
      .rsp_param_t       (rsp_param_t),
      .rsp_element_index (rsp_element_index),
      .rsp_is_restart    (rsp_is_restart),
      .rsp_last          (rsp_last)
   );

endmodule
